@@ sv/kqns_pkg.sv @@
package kqns_pkg;

   localparam int MAX_TRACKS_DEF  = 64;
   localparam int MAX_SAMPLES_DEF = 256;
   localparam int QUEUE_DEPTH     = 4;

   // csr register indexes
   localparam logic [2:0] CSR_FRAME_COUNT = 3'd0;
   localparam logic [2:0] CSR_END_FRAME   = 3'd1;
   localparam logic [2:0] CSR_PLAY_RATE   = 3'd2;
   localparam logic [2:0] CSR_LOOP_ENABLE = 3'd3;
   localparam logic [2:0] CSR_TRACK_COUNT = 3'd4;

   // request modes
   localparam logic [1:0] MODE_ROT    = 2'd0;
   localparam logic [1:0] MODE_ROOT   = 2'd1;
   localparam logic [1:0] MODE_SAMPLE = 2'd2;

   typedef enum logic [1:0] {
      OP_ROT,
      OP_ROOT,
      OP_SAMPLE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [5:0]  track;
      logic [7:0]  frame;
      logic [63:0] data;
      logic [7:0]  f0;
      logic [7:0]  f1;
      logic [14:0] alpha;
      logic [6:0]  tcount;
   } job_type;

   typedef struct packed {
      logic [7:0]  frame_count;
      logic [7:0]  end_frame;
      logic [15:0] play_rate;
      logic        loop_enable;
      logic [6:0]  track_count;
   } csr_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_CALC,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_RT0,
      B_RT1,
      B_RT2,
      B_RT3,
      B_KA,
      B_KB,
      B_KC,
      B_DOT,
      B_Q,
      B_SQ,
      B_SQRT,
      B_DSET,
      B_DRUN,
      B_OUT
   } back_state_type;

endpackage

@@ sv/kqns_front.sv @@
module kqns_front import kqns_pkg::*; #(
   parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  csr_type     csr,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_track,
   input  logic [7:0]  req_frame,
   input  logic [63:0] req_comp,
   input  logic [31:0] req_root_height,
   input  logic [31:0] req_time_q,
   output logic        push,
   output job_type     job,
   input  logic        full
);

   front_state_type state_ff, state_in;
   logic [31:0] time_ff, time_in;
   logic [23:0] int_ff, int_in;
   logic [23:0] frac_ff, frac_in;
   logic [7:0]  rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [47:0] prod;
   logic [7:0]  lim;
   logic [8:0]  rem_sh;
   logic [7:0]  f0;
   logic [7:0]  f1;
   logic [6:0]  ntrk;

   assign busy   = (state_ff != F_IDLE) || full;
   assign accept = start && !busy;
   assign prod   = time_ff * csr.play_rate;
   assign lim    = (csr.end_frame < csr.frame_count) ? csr.end_frame : csr.frame_count;
   assign rem_sh = {rem_ff, int_ff[23]};
   assign f0     = (int_ff > 24'(csr.frame_count)) ? csr.frame_count : int_ff[7:0];
   assign f1     = (({1'b0, f0} + 9'd1) > {1'b0, csr.frame_count}) ? csr.frame_count
                                                                   : 8'(f0 + 8'd1);
   assign ntrk   = (32'(csr.track_count) > MAX_TRACKS) ? 7'(MAX_TRACKS) : csr.track_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      time_ff <= time_in;
      int_ff  <= int_in;
      frac_ff <= frac_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      time_in  = time_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      job      = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_ROT: begin
                     if ((32'(req_frame) < MAX_SAMPLES) && (32'(req_track) < MAX_TRACKS)) begin
                        push      = 1'b1;
                        job.op    = OP_ROT;
                        job.track = req_track;
                        job.frame = req_frame;
                        job.data  = req_comp;
                     end
                  end
                  MODE_ROOT: begin
                     if (32'(req_frame) < MAX_SAMPLES) begin
                        push      = 1'b1;
                        job.op    = OP_ROOT;
                        job.frame = req_frame;
                        job.data  = {32'd0, req_root_height};
                     end
                  end
                  MODE_SAMPLE: begin
                     time_in  = req_time_q;
                     state_in = F_MUL;
                  end
                  default: ;
               endcase
            end
         end
         F_MUL: begin
            int_in   = prod[47:24];
            frac_in  = prod[23:0];
            state_in = F_CALC;
         end
         F_CALC: begin
            if (csr.loop_enable) begin
               if (csr.frame_count == 8'd0) begin
                  int_in   = '0;
                  frac_in  = '0;
                  state_in = F_PUSH;
               end else begin
                  rem_in   = '0;
                  cnt_in   = 5'd23;
                  state_in = F_DIV;
               end
            end else begin
               if ((int_ff > 24'(lim)) || ((int_ff == 24'(lim)) && (frac_ff != '0))) begin
                  int_in  = 24'(lim);
                  frac_in = '0;
               end
               state_in = F_PUSH;
            end
         end
         F_DIV: begin
            // one quotient bit per cycle, only the remainder is kept
            int_in = {int_ff[22:0], 1'b0};
            if (rem_sh >= {1'b0, csr.frame_count}) begin
               rem_in = 8'(rem_sh - {1'b0, csr.frame_count});
            end else begin
               rem_in = rem_sh[7:0];
            end
            if (cnt_ff == 5'd0) begin
               int_in   = 24'(rem_in);
               state_in = F_PUSH;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push       = 1'b1;
               job.op     = OP_SAMPLE;
               job.f0     = f0;
               job.f1     = f1;
               job.alpha  = frac_ff[23:9];
               job.tcount = ntrk;
               state_in   = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

endmodule

@@ sv/kqns_queue.sv @@
module kqns_queue import kqns_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type         slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [PW:0]     cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign head  = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (32'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (32'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

endmodule

@@ sv/kqns_back.sv @@
module kqns_back import kqns_pkg::*; #(
   parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  job_type     head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_out_track,
   output logic [15:0] rsp_rot_w,
   output logic [15:0] rsp_rot_x,
   output logic [15:0] rsp_rot_y,
   output logic [15:0] rsp_rot_z,
   output logic [31:0] rsp_out_root_height,
   output logic        rsp_last
);

   localparam int ROT_DEPTH = MAX_TRACKS * MAX_SAMPLES;
   localparam int AW        = (ROT_DEPTH > 1) ? $clog2(ROT_DEPTH) : 1;
   localparam int RW        = $clog2(MAX_SAMPLES);

   back_state_type state_ff, state_in;
   job_type     cur_ff, cur_in;
   logic [6:0]  t_ff, t_in;
   logic [1:0]  k_ff, k_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic signed [33:0] dot_ff, dot_in;
   logic signed [31:0] qv_ff [4];
   logic signed [31:0] qv_in [4];
   logic [63:0] n2_ff, n2_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [32:0] rem_ff, rem_in;
   logic [16:0] num_ff, num_in;
   logic [16:0] quot_ff, quot_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rot_ff [4];
   logic [15:0] rot_in [4];
   logic [31:0] root_ff, root_in;
   logic signed [31:0] ra_ff, ra_in;
   logic signed [48:0] pa_ff, pa_in;
   logic signed [48:0] pb_ff, pb_in;

   logic [63:0] rot_mem [ROT_DEPTH];
   logic [31:0] root_mem [MAX_SAMPLES];
   logic [63:0] rot_rd_ff;
   logic [31:0] root_rd_ff;
   logic        rot_oob_ff;
   logic        root_oob_ff;

   logic [7:0]  rot_frame;
   logic [7:0]  root_frame;
   logic [AW-1:0] rot_ra;
   logic [AW-1:0] rot_wa;
   logic [63:0] rot_data;
   logic [31:0] root_data;

   logic [15:0] inv;
   logic signed [15:0] sa;
   logic signed [15:0] sb;
   logic signed [31:0] pdot;
   logic signed [32:0] qa;
   logic signed [32:0] qb;
   logic signed [32:0] qsum;
   logic [31:0] qmag;
   logic [61:0] qsq;
   logic [63:0] sq_try;
   logic [31:0] norm;
   logic [47:0] numer;
   logic [32:0] dvs;
   logic [33:0] rem_sh;
   logic        ge;
   logic signed [49:0] root_sum;
   logic        is_last;

   assign inv      = 16'(17'd32768 - {2'b0, cur_ff.alpha});
   assign sa       = $signed(a_ff[16*k_ff +: 16]);
   assign sb       = $signed(b_ff[16*k_ff +: 16]);
   assign pdot     = sa * sb;
   assign qa       = 33'(sa) * $signed({17'd0, inv});
   assign qb       = 33'(sb) * $signed({18'd0, cur_ff.alpha});
   assign qsum     = dot_ff[33] ? (qa - qb) : (qa + qb);
   assign qmag     = qv_ff[k_ff][31] ? 32'(-qv_ff[k_ff]) : 32'(qv_ff[k_ff]);
   assign qsq      = qmag[30:0] * qmag[30:0];
   assign sq_try   = res_ff + bit_ff;
   assign norm     = res_ff[31:0];
   assign numer    = {1'b0, qmag[30:0], 16'd0} + 48'(norm);
   assign dvs      = {norm, 1'b0};
   assign rem_sh   = {rem_ff, num_ff[16]};
   assign ge       = rem_sh >= {1'b0, dvs};
   assign root_sum = 50'(pa_ff) + 50'(pb_ff) + 50'sd16384;
   assign is_last  = (t_ff + 7'd1) == cur_ff.tcount;
   assign rot_data = rot_oob_ff ? 64'd0 : rot_rd_ff;
   assign root_data = root_oob_ff ? 32'd0 : root_rd_ff;

   assign rot_frame  = (state_ff == B_KB) ? cur_ff.f1 : cur_ff.f0;
   assign root_frame = (state_ff == B_RT1) ? cur_ff.f1 : cur_ff.f0;
   assign rot_ra = AW'(32'(t_ff[5:0]) * MAX_SAMPLES + 32'(rot_frame));
   assign rot_wa = AW'(32'(head.track) * MAX_SAMPLES + 32'(head.frame));

   // key stores, one read port each
   always_ff @(posedge clock) begin
      if (pop && (head.op == OP_ROT)) begin
         rot_mem[rot_wa] <= head.data;
      end
      rot_rd_ff  <= rot_mem[rot_ra];
      rot_oob_ff <= 32'(rot_frame) >= MAX_SAMPLES;
   end

   always_ff @(posedge clock) begin
      if (pop && (head.op == OP_ROOT)) begin
         root_mem[RW'(head.frame)] <= head.data[31:0];
      end
      root_rd_ff  <= root_mem[RW'(root_frame)];
      root_oob_ff <= 32'(root_frame) >= MAX_SAMPLES;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff  <= cur_in;
      t_ff    <= t_in;
      k_ff    <= k_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      dot_ff  <= dot_in;
      qv_ff   <= qv_in;
      n2_ff   <= n2_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      rot_ff  <= rot_in;
      root_ff <= root_in;
      ra_ff   <= ra_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      dot_in   = dot_ff;
      qv_in    = qv_ff;
      n2_in    = n2_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      rot_in   = rot_ff;
      root_in  = root_ff;
      ra_in    = ra_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      pop      = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.op == OP_SAMPLE) begin
                  state_in = B_RT0;
               end
            end
         end
         B_RT0: state_in = B_RT1;
         B_RT1: begin
            ra_in    = $signed(root_data);
            state_in = B_RT2;
         end
         B_RT2: begin
            pa_in    = 49'(ra_ff) * $signed({33'd0, inv});
            pb_in    = 49'($signed(root_data)) * $signed({34'd0, cur_ff.alpha});
            state_in = B_RT3;
         end
         B_RT3: begin
            root_in  = root_sum[46:15];
            t_in     = '0;
            state_in = (cur_ff.tcount == '0) ? B_IDLE : B_KA;
         end
         B_KA: state_in = B_KB;
         B_KB: begin
            a_in     = rot_data;
            state_in = B_KC;
         end
         B_KC: begin
            b_in     = rot_data;
            k_in     = '0;
            dot_in   = '0;
            state_in = B_DOT;
         end
         B_DOT: begin
            dot_in = dot_ff + 34'(pdot);
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = B_Q;
            end
         end
         B_Q: begin
            // second key flipped when the keys lie in opposite hemispheres
            qv_in[k_ff] = qsum[31:0];
            k_in        = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               n2_in    = '0;
               state_in = B_SQ;
            end
         end
         B_SQ: begin
            n2_in = n2_ff + 64'(qsq);
            k_in  = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            if (n2_ff >= sq_try) begin
               n2_in  = n2_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               k_in     = '0;
               state_in = B_DSET;
            end
         end
         B_DSET: begin
            if (norm == '0) begin
               rot_in[k_ff] = '0;
               k_in         = k_ff + 2'd1;
               state_in     = (k_ff == 2'd3) ? B_OUT : B_DSET;
            end else begin
               rem_in   = 33'(numer[47:17]);
               num_in   = numer[16:0];
               quot_in  = '0;
               cnt_in   = 5'd16;
               state_in = B_DRUN;
            end
         end
         B_DRUN: begin
            rem_in  = ge ? 33'(rem_sh - {1'b0, dvs}) : rem_sh[32:0];
            num_in  = {num_ff[15:0], 1'b0};
            quot_in = {quot_ff[15:0], ge};
            if (cnt_ff == '0) begin
               if (qv_ff[k_ff][31]) begin
                  rot_in[k_ff] = (quot_in > 17'd32768) ? 16'h8000 : 16'(17'd0 - quot_in);
               end else begin
                  rot_in[k_ff] = (quot_in > 17'd32767) ? 16'h7FFF : quot_in[15:0];
               end
               k_in     = k_ff + 2'd1;
               state_in = (k_ff == 2'd3) ? B_OUT : B_DSET;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         B_OUT: begin
            t_in     = t_ff + 7'd1;
            state_in = is_last ? B_IDLE : B_KA;
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_strobe          = (state_ff == B_OUT);
   assign rsp_out_track       = t_ff[5:0];
   assign rsp_rot_w           = rot_ff[0];
   assign rsp_rot_x           = rot_ff[1];
   assign rsp_rot_y           = rot_ff[2];
   assign rsp_rot_z           = rot_ff[3];
   assign rsp_out_root_height = root_ff;
   assign rsp_last            = is_last;

endmodule

@@ sv/keyframe_quaternion_nlerp_sampler.sv @@
// Keyframe rotation sampler. In-range load beats (mode 0 rotation key, mode 1 root height)
// are stored in order with samples; a sample beat (mode 2) emits one result per track,
// each on the rsp_ ports for exactly one cycle with rsp_strobe high and rsp_last on the
// final track. The receiver cannot stall, so every result must be taken in the cycle it shows.
// A sample passes the front end's multiply, a clamp or (in loop mode) a frame-count modulo,
// and its push; the back end reads and blends the root height, then for each track in turn
// does two key reads, 4 dot and 4 lerp steps, 4 squares, a 32-step square root and four
// restoring divides on one shared divider. start is taken whenever busy is low; the front
// end may run ahead of the back end by up to four queued beats. The user must write
// registers through csr_ only while the block is idle; the block does not enforce this.
module keyframe_quaternion_nlerp_sampler import kqns_pkg::*; #(
   parameter int MAX_TRACKS  = MAX_TRACKS_DEF,
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_track,
   input  logic [7:0]  req_frame,
   input  logic [15:0] req_comp_w,
   input  logic [15:0] req_comp_x,
   input  logic [15:0] req_comp_y,
   input  logic [15:0] req_comp_z,
   input  logic [31:0] req_root_height,
   input  logic [31:0] req_time_q,
   // result channel
   output logic        rsp_strobe,
   output logic [5:0]  rsp_out_track,
   output logic [15:0] rsp_rot_w,
   output logic [15:0] rsp_rot_x,
   output logic [15:0] rsp_rot_y,
   output logic [15:0] rsp_rot_z,
   output logic [31:0] rsp_out_root_height,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   csr_type csr_ff, csr_in;

   logic    push;
   job_type push_job;
   logic    pop;
   job_type head;
   logic    empty;
   logic    full;

   // registers always take a beat
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_COUNT: csr_in.frame_count = csr_data[7:0];
            CSR_END_FRAME:   csr_in.end_frame   = csr_data[7:0];
            CSR_PLAY_RATE:   csr_in.play_rate   = csr_data;
            CSR_LOOP_ENABLE: csr_in.loop_enable = csr_data[0];
            CSR_TRACK_COUNT: csr_in.track_count = csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_count <= 8'd1;
         csr_ff.end_frame   <= 8'd1;
         csr_ff.play_rate   <= 16'd15360;   // 60 fps in Q8.8
         csr_ff.loop_enable <= 1'b0;
         csr_ff.track_count <= 7'd1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front end: range-checks loads, turns time into frame index and fraction
   kqns_front #(
      .MAX_TRACKS  (MAX_TRACKS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_track       (req_track),
      .req_frame       (req_frame),
      .req_comp        ({req_comp_z, req_comp_y, req_comp_x, req_comp_w}),
      .req_root_height (req_root_height),
      .req_time_q      (req_time_q),
      .push            (push),
      .job             (push_job),
      .full            (full)
   );

   // keeps loads and samples in arrival order
   kqns_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // back end: key stores, per-track nlerp and normalize
   kqns_back #(
      .MAX_TRACKS  (MAX_TRACKS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .empty               (empty),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_track       (rsp_out_track),
      .rsp_rot_w           (rsp_rot_w),
      .rsp_rot_x           (rsp_rot_x),
      .rsp_rot_y           (rsp_rot_y),
      .rsp_rot_z           (rsp_rot_z),
      .rsp_out_root_height (rsp_out_root_height),
      .rsp_last            (rsp_last)
   );

endmodule
